// ===== hdl/mac_pkg.sv =====
// ----------------------------------------------------------------------------
// mac_pkg
// Shared types and constants for the moving average crossover detector.
// ----------------------------------------------------------------------------
package mac_pkg;

   localparam int PRICE_W     = 32;
   localparam int INDEX_W     = 32;
   localparam int SHORT_W     = 8;
   localparam int LONG_W      = 9;
   localparam int CSR_DATA_W  = 9;
   localparam int CSR_INDEX_W = 1;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_SHORT_WINDOW = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_WINDOW  = 1'b1;

   localparam logic [SHORT_W-1:0] SHORT_RESET = 8'd3;
   localparam logic [LONG_W-1:0]  LONG_RESET  = 9'd5;

   // Relation of the short average to the long average.
   localparam logic [1:0] REL_NONE  = 2'd0;
   localparam logic [1:0] REL_EQUAL = 2'd1;
   localparam logic [1:0] REL_ABOVE = 2'd2;
   localparam logic [1:0] REL_BELOW = 2'd3;

   typedef struct packed {
      logic [PRICE_W-1:0] price;
      logic               restart;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] sample_index;
      logic               is_buy;
   } rsp_type;

   // Per-request control that follows the price down the pipeline.
   typedef struct packed {
      logic               restart;
      logic               sub_short;
      logic               sub_long;
      logic               eval;
      logic [INDEX_W-1:0] idx;
   } ctl_type;

endpackage

// ===== hdl/moving_average_crossover_detector.sv =====
// ----------------------------------------------------------------------------
// moving_average_crossover_detector
// Moving average crossover detector. Each request carries one unsigned price
// and a restart flag; the block keeps a delay line of WINDOW_DEPTH prices and
// running sums over the short and long windows. Once a series holds a full
// long window, the two averages are compared exactly, and a response is sent
// when the short average crosses above (buy) or below (sell) the long one,
// tagged with the saturating sample index. The first comparison of a series
// only records the relation. One request is taken every clock cycle; a
// response passes through three register stages: delay-line read, the
// running-sum update, and the cross-multiply compare. Back-pressure on the
// response side stalls the pipeline only once those stages are full. A write
// to either window register restarts the series, and a short window that is
// zero or not below the long window, or a long window beyond WINDOW_DEPTH,
// produces no responses. The delay line needs no clearing after reset: only
// slots written within the current series are read.
// ----------------------------------------------------------------------------
module moving_average_crossover_detector #(
   parameter int WINDOW_DEPTH = 256,
   parameter int PRICE_BITS   = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  mac_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output mac_pkg::rsp_type                rsp_data,
   input  logic                            csr_we,
   input  logic [mac_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mac_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int PW = (PRICE_BITS < mac_pkg::PRICE_W) ? PRICE_BITS : mac_pkg::PRICE_W;
   localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int SW = PW + AW;

   logic [mac_pkg::SHORT_W-1:0] short_window_ff;
   logic [mac_pkg::LONG_W-1:0]  long_window_ff;
   logic                        cfg_ok;

   logic                        a_valid, b_ready, b_valid, out_free;
   mac_pkg::ctl_type            a_ctl, b_ctl;
   logic [PW-1:0]               a_price, a_old_short, a_old_long;
   logic [SW-1:0]               short_sum, long_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         short_window_ff <= mac_pkg::SHORT_RESET;
         long_window_ff  <= mac_pkg::LONG_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            mac_pkg::CSR_SHORT_WINDOW: begin
               short_window_ff <= csr_wdata[mac_pkg::SHORT_W-1:0];
            end
            mac_pkg::CSR_LONG_WINDOW: begin
               long_window_ff <= csr_wdata[mac_pkg::LONG_W-1:0];
            end
            default: begin
               short_window_ff <= short_window_ff;
            end
         endcase
      end
   end

   assign cfg_ok = (short_window_ff != '0) &&
                   (mac_pkg::LONG_W'(short_window_ff) < long_window_ff) &&
                   (32'(long_window_ff) <= 32'(WINDOW_DEPTH));

   mac_history #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .PW           (PW)
   ) u_history (
      .clock        (clock),
      .reset        (reset),
      .clear        (csr_we),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .price_i      (req_data.price[PW-1:0]),
      .restart_i    (req_data.restart),
      .short_window (short_window_ff),
      .long_window  (long_window_ff),
      .cfg_ok       (cfg_ok),
      .b_ready      (b_ready),
      .a_valid      (a_valid),
      .a_ctl        (a_ctl),
      .a_price      (a_price),
      .a_old_short  (a_old_short),
      .a_old_long   (a_old_long)
   );

   mac_sums #(
      .PW          (PW),
      .SW          (SW)
   ) u_sums (
      .clock       (clock),
      .reset       (reset),
      .clear       (csr_we),
      .cfg_ok      (cfg_ok),
      .a_valid     (a_valid),
      .a_ctl       (a_ctl),
      .a_price     (a_price),
      .a_old_short (a_old_short),
      .a_old_long  (a_old_long),
      .out_free    (out_free),
      .b_ready     (b_ready),
      .b_valid     (b_valid),
      .b_ctl       (b_ctl),
      .short_sum   (short_sum),
      .long_sum    (long_sum)
   );

   mac_compare #(
      .SW           (SW)
   ) u_compare (
      .clock        (clock),
      .reset        (reset),
      .clear        (csr_we),
      .short_window (short_window_ff),
      .long_window  (long_window_ff),
      .b_valid      (b_valid),
      .b_ctl        (b_ctl),
      .short_sum    (short_sum),
      .long_sum     (long_sum),
      .out_free     (out_free),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

endmodule

// ===== hdl/mac_history.sv =====
// ----------------------------------------------------------------------------
// mac_history
// Delay line of prices, write pointer and sample counter. Registers the
// incoming request together with the two prices that leave the windows.
// ----------------------------------------------------------------------------
module mac_history #(
   parameter int WINDOW_DEPTH = 256,
   parameter int PW           = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        clear,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [PW-1:0]               price_i,
   input  logic                        restart_i,
   input  logic [mac_pkg::SHORT_W-1:0] short_window,
   input  logic [mac_pkg::LONG_W-1:0]  long_window,
   input  logic                        cfg_ok,
   input  logic                        b_ready,
   output logic                        a_valid,
   output mac_pkg::ctl_type            a_ctl,
   output logic [PW-1:0]               a_price,
   output logic [PW-1:0]               a_old_short,
   output logic [PW-1:0]               a_old_long
);

   localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int XW = ((AW > mac_pkg::LONG_W) ? AW : mac_pkg::LONG_W) + 2;

   logic [PW-1:0] mem [WINDOW_DEPTH];

   logic [AW-1:0]               wp_ff, wp_in;
   logic [mac_pkg::INDEX_W-1:0] count_ff, count_in;
   logic                        a_valid_ff, a_valid_in;
   mac_pkg::ctl_type            ctl_ff, ctl_in;
   logic [PW-1:0]               price_ff;
   logic [PW-1:0]               old_short_ff;
   logic [PW-1:0]               old_long_ff;

   logic                        accept;
   logic [AW-1:0]               wp_used;
   logic [mac_pkg::INDEX_W-1:0] idx;
   logic [XW-1:0]               span_s, span_l;
   logic [AW-1:0]               addr_s, addr_l;

   assign req_ready = !a_valid_ff || b_ready;
   assign accept    = req_valid && req_ready;

   assign wp_used = restart_i ? '0 : wp_ff;
   assign idx     = restart_i ? '0 : count_ff;

   // Slot that lies a window length behind the current write slot.
   always_comb begin
      span_s = XW'(wp_used) + XW'(WINDOW_DEPTH) - XW'(short_window);
      span_l = XW'(wp_used) + XW'(WINDOW_DEPTH) - XW'(long_window);
      if (span_s >= XW'(WINDOW_DEPTH)) begin
         span_s = span_s - XW'(WINDOW_DEPTH);
      end
      if (span_l >= XW'(WINDOW_DEPTH)) begin
         span_l = span_l - XW'(WINDOW_DEPTH);
      end
      addr_s = cfg_ok ? span_s[AW-1:0] : '0;
      addr_l = cfg_ok ? span_l[AW-1:0] : '0;
   end

   always_comb begin
      wp_in    = (wp_used == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_used + AW'(1);
      count_in = (idx == '1) ? idx : idx + mac_pkg::INDEX_W'(1);

      ctl_in.restart   = restart_i;
      ctl_in.idx       = idx;
      ctl_in.sub_short = idx >= mac_pkg::INDEX_W'(short_window);
      ctl_in.sub_long  = idx >= mac_pkg::INDEX_W'(long_window);
      ctl_in.eval      = cfg_ok &&
                         ((33'(idx) + 33'd1) >= 33'(long_window));

      if (accept) begin
         a_valid_in = 1'b1;
      end else if (a_valid_ff && b_ready) begin
         a_valid_in = 1'b0;
      end else begin
         a_valid_in = a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         count_ff   <= '0;
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         if (clear) begin
            wp_ff    <= '0;
            count_ff <= '0;
         end else if (accept) begin
            wp_ff    <= wp_in;
            count_ff <= count_in;
         end
      end
   end

   // Reads return the old contents, which matters when the long window
   // spans the whole delay line and reads the slot being overwritten.
   always_ff @(posedge clock) begin
      if (accept) begin
         mem[wp_used] <= price_i;
         old_short_ff <= mem[addr_s];
         old_long_ff  <= mem[addr_l];
         price_ff     <= price_i;
         ctl_ff       <= ctl_in;
      end
   end

   assign a_valid     = a_valid_ff;
   assign a_ctl       = ctl_ff;
   assign a_price     = price_ff;
   assign a_old_short = old_short_ff;
   assign a_old_long  = old_long_ff;

endmodule

// ===== hdl/mac_sums.sv =====
// ----------------------------------------------------------------------------
// mac_sums
// Running sums of the short and long windows, one add and one subtract
// per request.
// ----------------------------------------------------------------------------
module mac_sums #(
   parameter int PW = 32,
   parameter int SW = 40
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             clear,
   input  logic             cfg_ok,
   input  logic             a_valid,
   input  mac_pkg::ctl_type a_ctl,
   input  logic [PW-1:0]    a_price,
   input  logic [PW-1:0]    a_old_short,
   input  logic [PW-1:0]    a_old_long,
   input  logic             out_free,
   output logic             b_ready,
   output logic             b_valid,
   output mac_pkg::ctl_type b_ctl,
   output logic [SW-1:0]    short_sum,
   output logic [SW-1:0]    long_sum
);

   logic             b_valid_ff, b_valid_in;
   mac_pkg::ctl_type ctl_ff;
   logic [SW-1:0]    short_sum_ff, short_sum_in;
   logic [SW-1:0]    long_sum_ff, long_sum_in;
   logic             a_move;
   logic [SW-1:0]    base_s, base_l;

   assign b_ready = !b_valid_ff || out_free;
   assign a_move  = a_valid && b_ready;

   always_comb begin
      base_s = a_ctl.restart ? '0 : short_sum_ff;
      base_l = a_ctl.restart ? '0 : long_sum_ff;
      short_sum_in = base_s;
      long_sum_in  = base_l;
      // Intermediate wrap is harmless: the final sum always fits.
      if (cfg_ok) begin
         short_sum_in = base_s + SW'(a_price) -
                        (a_ctl.sub_short ? SW'(a_old_short) : '0);
         long_sum_in  = base_l + SW'(a_price) -
                        (a_ctl.sub_long ? SW'(a_old_long) : '0);
      end

      if (a_move) begin
         b_valid_in = 1'b1;
      end else if (b_valid_ff && out_free) begin
         b_valid_in = 1'b0;
      end else begin
         b_valid_in = b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         short_sum_ff <= '0;
         long_sum_ff  <= '0;
      end else begin
         b_valid_ff <= b_valid_in;
         if (clear) begin
            short_sum_ff <= '0;
            long_sum_ff  <= '0;
         end else if (a_move) begin
            short_sum_ff <= short_sum_in;
            long_sum_ff  <= long_sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_move) begin
         ctl_ff <= a_ctl;
      end
   end

   assign b_valid   = b_valid_ff;
   assign b_ctl     = ctl_ff;
   assign short_sum = short_sum_ff;
   assign long_sum  = long_sum_ff;

endmodule

// ===== hdl/mac_compare.sv =====
// ----------------------------------------------------------------------------
// mac_compare
// Compares the two averages by cross-multiplication, tracks the previous
// relation and registers the crossing result.
// ----------------------------------------------------------------------------
module mac_compare #(
   parameter int SW = 40
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        clear,
   input  logic [mac_pkg::SHORT_W-1:0] short_window,
   input  logic [mac_pkg::LONG_W-1:0]  long_window,
   input  logic                        b_valid,
   input  mac_pkg::ctl_type            b_ctl,
   input  logic [SW-1:0]               short_sum,
   input  logic [SW-1:0]               long_sum,
   output logic                        out_free,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output mac_pkg::rsp_type            rsp_data
);

   localparam int PRW = SW + mac_pkg::LONG_W;

   logic             rsp_valid_ff, rsp_valid_in;
   mac_pkg::rsp_type rsp_data_ff;
   logic [1:0]       prior_ff, prior_in;

   logic             b_move;
   logic [PRW-1:0]   prod_s, prod_l;
   logic [1:0]       rel, prior_base;
   logic             emit, up;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign b_move   = b_valid && out_free;

   // short_sum / short_window against long_sum / long_window, exactly.
   assign prod_s = PRW'(short_sum) * PRW'(long_window);
   assign prod_l = PRW'(long_sum) * PRW'(short_window);

   always_comb begin
      if (prod_s > prod_l) begin
         rel = mac_pkg::REL_ABOVE;
      end else if (prod_s < prod_l) begin
         rel = mac_pkg::REL_BELOW;
      end else begin
         rel = mac_pkg::REL_EQUAL;
      end

      prior_base = b_ctl.restart ? mac_pkg::REL_NONE : prior_ff;
      prior_in   = b_ctl.eval ? rel : prior_base;

      up   = (rel == mac_pkg::REL_ABOVE) && (prior_base != mac_pkg::REL_ABOVE);
      emit = b_ctl.eval && (prior_base != mac_pkg::REL_NONE) &&
             (up || ((rel == mac_pkg::REL_BELOW) &&
                     (prior_base != mac_pkg::REL_BELOW)));

      rsp_valid_in = out_free ? (b_move && emit) : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         prior_ff     <= mac_pkg::REL_NONE;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (clear) begin
            prior_ff <= mac_pkg::REL_NONE;
         end else if (b_move) begin
            prior_ff <= prior_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (b_move && emit) begin
         rsp_data_ff.sample_index <= b_ctl.idx;
         rsp_data_ff.is_buy       <= up;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hdl/mac_checker.sv =====
// ----------------------------------------------------------------------------
// mac_checker
// Port-level checks for the moving average crossover detector.
// ----------------------------------------------------------------------------
module mac_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input mac_pkg::rsp_type rsp_data
);

   // A waiting response holds still until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed or dropped while stalled");

   // Requests are refused only when a response is stuck at the output.
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request refused without output back-pressure");

   // Reset leaves no response pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response pending after reset");

   // A crossing needs a full long window plus an earlier comparison.
   a_index_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.sample_index != '0)
      else $error("response for the first sample of a series");

endmodule

bind moving_average_crossover_detector mac_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
